// ----- sv/lvcp_pkg.sv -----
package lvcp_pkg;

  localparam int LVCP_MAX_MESSAGE = 1024;

  localparam int NREG = 13;

  // Letter register indexes.
  localparam logic [3:0] RI_G = 4'd0;
  localparam logic [3:0] RI_D = 4'd1;
  localparam logic [3:0] RI_S = 4'd2;
  localparam logic [3:0] RI_F = 4'd3;
  localparam logic [3:0] RI_X = 4'd4;
  localparam logic [3:0] RI_Y = 4'd5;
  localparam logic [3:0] RI_W = 4'd6;
  localparam logic [3:0] RI_H = 4'd7;
  localparam logic [3:0] RI_U = 4'd8;
  localparam logic [3:0] RI_P = 4'd9;
  localparam logic [3:0] RI_R = 4'd10;
  localparam logic [3:0] RI_T = 4'd11;
  localparam logic [3:0] RI_C = 4'd12;

  // Result kinds.
  localparam logic [1:0] KIND_KNOWN   = 2'd0;
  localparam logic [1:0] KIND_UNKNOWN = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_EXPECT_LETTER = 2'd1;
  localparam logic [1:0] ST_BAD_LETTER   = 2'd2;

  // Characters.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [15:0] G_SET_GRID  = 16'd50;
  localparam logic [15:0] GRID_W_INIT = 16'd6;
  localparam logic [15:0] GRID_H_INIT = 16'd9;
  localparam logic [15:0] CNT_SAT     = 16'hFFFF;

  typedef logic [NREG-1:0][15:0] regs_t;

  localparam regs_t REGS_INIT = '{RI_P: 16'd1, default: 16'd0};

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_SIGN   = 4'b0010,
    MODE_DIGITS = 4'b0100,
    MODE_STRING = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] command;
    logic [15:0] device;
    logic [15:0] sensor;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] precision;
    logic [9:0]  text_start;
    logic [10:0] text_length;
    logic [1:0]  status;
    logic [15:0] line_count;
    logic [15:0] char_count;
  } result_t;

  typedef struct packed {
    logic head_valid;
    logic room;
  } q_status_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } lookup_t;

  // Maps an uppercase letter to its register index.
  function automatic lookup_t reg_lookup(input logic [7:0] up);
    lookup_t r;
    r.hit = 1'b1;
    r.idx = RI_G;
    unique case (up)
      "G": r.idx = RI_G;
      "D": r.idx = RI_D;
      "S": r.idx = RI_S;
      "F": r.idx = RI_F;
      "X": r.idx = RI_X;
      "Y": r.idx = RI_Y;
      "W": r.idx = RI_W;
      "H": r.idx = RI_H;
      "U": r.idx = RI_U;
      "P": r.idx = RI_P;
      "R": r.idx = RI_R;
      "T": r.idx = RI_T;
      "C": r.idx = RI_C;
      default: r.hit = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/lvcp_core.sv -----
module lvcp_core import lvcp_pkg::*; #(
  parameter int MAX_MESSAGE = LVCP_MAX_MESSAGE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] ch,
  input  logic       start_req,
  output logic [1:0] res_cnt,
  output result_t    res0,
  output result_t    res1
);

  localparam int IDX_W = $clog2(MAX_MESSAGE + 1);
  localparam int OFF_W = $clog2(MAX_MESSAGE);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_MESSAGE);
  localparam logic [IDX_W:0]   IDX_MAX_X = (IDX_W + 1)'(MAX_MESSAGE);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_MESSAGE - 1);

  regs_t            regs_r, regs_nxt, e_regs;
  logic [15:0]      gw_r, gw_nxt, e_gw;
  logic [15:0]      gh_r, gh_nxt, e_gh;
  mode_t            mode_r, mode_nxt, e_mode;
  logic [15:0]      acc_r, acc_nxt, e_acc;
  logic             minus_r, minus_nxt, e_minus;
  logic [3:0]       tgt_r, tgt_nxt, e_tgt;
  logic             tlow_r, tlow_nxt, e_tlow;
  logic             pend_r, pend_nxt, e_pend;
  logic [15:0]      nlc_r, nlc_nxt, e_nlc;
  logic [15:0]      cc_r, cc_nxt, e_cc;
  logic [OFF_W-1:0] soff_r, soff_nxt, e_soff;
  logic [IDX_W-1:0] slen_r, slen_nxt, e_slen;
  logic [IDX_W-1:0] bidx_r, bidx_nxt, e_bidx;
  logic             halted_r, halted_nxt, e_halted;

  logic             done;
  logic [15:0]      cval;
  logic [3:0]       ctgt;
  logic [31:0]      prod;
  logic [15:0]      gval;
  logic             known;
  logic [IDX_W:0]   bidx_inc;
  logic             is_upper, is_lower;
  lookup_t          lk;

  function automatic result_t mk_res(input logic [1:0] kind, input logic [1:0] status,
                                     input regs_t r, input logic [OFF_W-1:0] soff,
                                     input logic [IDX_W-1:0] slen, input logic [15:0] nlc,
                                     input logic [15:0] cc);
    result_t o;
    o.kind        = kind;
    o.command     = r[RI_G];
    o.device      = r[RI_D];
    o.sensor      = r[RI_S];
    o.x_pos       = r[RI_X];
    o.y_pos       = r[RI_Y];
    o.precision   = r[RI_P];
    o.text_start  = 10'(soff);
    o.text_length = 11'(slen);
    o.status      = status;
    o.line_count  = nlc;
    o.char_count  = cc;
    return o;
  endfunction

  // A start request makes the byte see the state as it is after reset.
  always_comb begin
    if (start_req) begin
      e_regs = REGS_INIT;  e_gw = GRID_W_INIT;  e_gh = GRID_H_INIT;
      e_mode = MODE_IDLE;  e_acc = '0;  e_minus = 1'b0;  e_tgt = '0;  e_tlow = 1'b0;
      e_pend = 1'b0;  e_nlc = '0;  e_cc = '0;  e_soff = '0;  e_slen = '0;
      e_bidx = '0;  e_halted = 1'b0;
    end else begin
      e_regs = regs_r;  e_gw = gw_r;  e_gh = gh_r;
      e_mode = mode_r;  e_acc = acc_r;  e_minus = minus_r;  e_tgt = tgt_r;  e_tlow = tlow_r;
      e_pend = pend_r;  e_nlc = nlc_r;  e_cc = cc_r;  e_soff = soff_r;  e_slen = slen_r;
      e_bidx = bidx_r;  e_halted = halted_r;
    end
  end

  always_comb begin
    regs_nxt = e_regs;  gw_nxt = e_gw;  gh_nxt = e_gh;
    mode_nxt = e_mode;  acc_nxt = e_acc;  minus_nxt = e_minus;  tgt_nxt = e_tgt;
    tlow_nxt = e_tlow;  pend_nxt = e_pend;  nlc_nxt = e_nlc;  cc_nxt = e_cc;
    soff_nxt = e_soff;  slen_nxt = e_slen;  halted_nxt = e_halted;
    bidx_nxt = (e_bidx < IDX_MAX) ? e_bidx + 1'b1 : e_bidx;
    bidx_inc = {1'b0, e_bidx} + 1'b1;
    res_cnt  = 2'd0;
    res0     = '0;
    res1     = '0;
    done     = e_halted;
    cval     = e_minus ? 16'(16'd0 - e_acc) : e_acc;
    ctgt     = (e_tgt < 4'(NREG)) ? e_tgt : RI_G;
    prod     = '0;
    gval     = '0;
    known    = 1'b0;
    is_upper = (ch >= CH_UP_A) && (ch <= CH_UP_Z);
    is_lower = (ch >= CH_LO_A) && (ch <= CH_LO_Z);
    lk       = reg_lookup(is_lower ? ch - CASE_GAP : ch);

    if (e_halted) begin
      bidx_nxt = e_bidx;
    end

    // Inside a string every byte up to the end of the line or message is payload.
    if (!done && e_mode == MODE_STRING) begin
      if (ch != CH_LF && ch != CH_NUL) begin
        if (e_slen < IDX_MAX) begin
          slen_nxt = e_slen + 1'b1;
        end
        done = 1'b1;
      end else begin
        mode_nxt = MODE_IDLE;
      end
    end

    if (!done && mode_nxt == MODE_SIGN && ch == CH_MINUS) begin
      minus_nxt = 1'b1;
      if (e_cc != CNT_SAT) cc_nxt = e_cc + 1'b1;
      mode_nxt = MODE_DIGITS;
      done = 1'b1;
    end

    if (!done && (mode_nxt == MODE_SIGN || mode_nxt == MODE_DIGITS)) begin
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
        acc_nxt = 16'({e_acc, 3'b000} + {e_acc, 1'b0} + {8'd0, ch - CH_ZERO});
        if (e_cc != CNT_SAT) cc_nxt = e_cc + 1'b1;
        mode_nxt = MODE_DIGITS;
        done = 1'b1;
      end else begin
        // Any other byte closes the value and stores it.
        regs_nxt[ctgt] = cval;
        if (!e_tlow && ctgt == RI_R) begin
          prod = cval * e_gh;
          regs_nxt[RI_Y] = prod[15:0];
        end else if (!e_tlow && ctgt == RI_C) begin
          prod = cval * e_gw;
          regs_nxt[RI_X] = prod[15:0];
        end
        pend_nxt = 1'b1;
        mode_nxt = MODE_IDLE;
      end
    end

    gval  = regs_nxt[RI_G];
    known = (gval <= 16'd2) || (gval >= 16'd4 && gval <= 16'd8) || (gval == G_SET_GRID);

    if (!done) begin
      case (ch) inside
        CH_NUL: begin
          if (pend_nxt) begin
            res0 = mk_res(known ? KIND_KNOWN : KIND_UNKNOWN, ST_OK, regs_nxt, soff_nxt,
                          slen_nxt, nlc_nxt, cc_nxt);
            res1 = mk_res(KIND_END, ST_OK, regs_nxt, soff_nxt, slen_nxt, nlc_nxt, cc_nxt);
            res_cnt = 2'd2;
            if (gval == G_SET_GRID) begin
              gw_nxt = regs_nxt[RI_W];
              gh_nxt = regs_nxt[RI_H];
            end
          end else begin
            res0 = mk_res(KIND_END, ST_OK, regs_nxt, soff_nxt, slen_nxt, nlc_nxt, cc_nxt);
            res_cnt = 2'd1;
          end
          pend_nxt   = 1'b0;
          halted_nxt = 1'b1;
          bidx_nxt   = e_bidx;
        end
        CH_SPACE, CH_CR: begin
        end
        CH_QUOTE: begin
          mode_nxt = MODE_STRING;
          soff_nxt = (bidx_inc < IDX_MAX_X) ? OFF_W'(bidx_inc) : OFF_MAX;
          slen_nxt = '0;
        end
        CH_LF: begin
          if (pend_nxt) begin
            res0 = mk_res(known ? KIND_KNOWN : KIND_UNKNOWN, ST_OK, regs_nxt, soff_nxt,
                          slen_nxt, nlc_nxt, cc_nxt);
            res_cnt = 2'd1;
            if (gval == G_SET_GRID) begin
              gw_nxt = regs_nxt[RI_W];
              gh_nxt = regs_nxt[RI_H];
            end
          end
          if (e_nlc != CNT_SAT) nlc_nxt = e_nlc + 1'b1;
          pend_nxt = 1'b0;
        end
        default: begin
          if (e_cc != CNT_SAT) cc_nxt = e_cc + 1'b1;
          if (!is_upper && !is_lower) begin
            res0 = mk_res(KIND_END, ST_EXPECT_LETTER, regs_nxt, soff_nxt, slen_nxt, nlc_nxt,
                          cc_nxt);
            res_cnt    = 2'd1;
            halted_nxt = 1'b1;
            bidx_nxt   = e_bidx;
          end else if (!lk.hit) begin
            res0 = mk_res(KIND_END, ST_BAD_LETTER, regs_nxt, soff_nxt, slen_nxt, nlc_nxt,
                          cc_nxt);
            res_cnt    = 2'd1;
            halted_nxt = 1'b1;
            bidx_nxt   = e_bidx;
          end else begin
            tgt_nxt   = lk.idx;
            tlow_nxt  = is_lower;
            acc_nxt   = '0;
            minus_nxt = 1'b0;
            mode_nxt  = MODE_SIGN;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r   <= REGS_INIT;
      gw_r     <= GRID_W_INIT;
      gh_r     <= GRID_H_INIT;
      mode_r   <= MODE_IDLE;
      acc_r    <= '0;
      minus_r  <= 1'b0;
      tgt_r    <= '0;
      tlow_r   <= 1'b0;
      pend_r   <= 1'b0;
      nlc_r    <= '0;
      cc_r     <= '0;
      soff_r   <= '0;
      slen_r   <= '0;
      bidx_r   <= '0;
      halted_r <= 1'b0;
    end else if (accept) begin
      regs_r   <= regs_nxt;
      gw_r     <= gw_nxt;
      gh_r     <= gh_nxt;
      mode_r   <= mode_nxt;
      acc_r    <= acc_nxt;
      minus_r  <= minus_nxt;
      tgt_r    <= tgt_nxt;
      tlow_r   <= tlow_nxt;
      pend_r   <= pend_nxt;
      nlc_r    <= nlc_nxt;
      cc_r     <= cc_nxt;
      soff_r   <= soff_nxt;
      slen_r   <= slen_nxt;
      bidx_r   <= bidx_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

// ----- sv/lvcp_out_queue.sv -----
module lvcp_out_queue import lvcp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_cnt,
  input  result_t    push0,
  input  result_t    push1,
  input  logic       pop,
  output result_t    head,
  output q_status_t  status
);

  localparam int DEPTH = 3;

  result_t    slot_r   [DEPTH];
  result_t    slot_nxt [DEPTH];
  logic [1:0] cnt_r, cnt_nxt, base;

  // Entries move towards slot 0 on a pop; new results land behind the survivors.
  always_comb begin
    base = cnt_r - {1'b0, pop};
    for (int i = 0; i < DEPTH; i++) begin
      slot_nxt[i] = (pop && i < DEPTH - 1) ? slot_r[(i < DEPTH - 1) ? i + 1 : i] : slot_r[i];
      if (push_cnt != 2'd0 && 2'(i) == base) begin
        slot_nxt[i] = push0;
      end
      if (push_cnt == 2'd2 && 2'(i) == 2'(base + 2'd1)) begin
        slot_nxt[i] = push1;
      end
    end
    cnt_nxt = base + push_cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_r[i] <= slot_nxt[i];
    end
  end

  assign head              = slot_r[0];
  assign status.head_valid = (cnt_r != 2'd0);
  assign status.room       = (cnt_r <= 2'd1);

endmodule

// ----- sv/letter_value_command_parser.sv -----
// Channel  Direction  Handshake                Payload
// in_      slave      in_tvalid / in_tready    tdata: ch; tuser: start_req
// out_     master     out_tvalid / out_tready  tdata: register fields; tuser: kind
//
// Each byte is parsed in the cycle it is accepted, so one byte is taken per cycle while in_tready is high.
// A byte may raise up to two results (a final command and the end of message); the
// three-entry result queue takes a byte whenever at most one result is waiting, so a
// byte that raises two results holds off the next byte until the sink takes one.
// A result reaches the output in the cycle after its byte is accepted if none is ahead.
// Reset (rst_n low, synchronous) restores the parser state and empties the queue.
// Stalls on the output side hold the head result and close in_tready once two wait.
module letter_value_command_parser import lvcp_pkg::*; #(
  parameter int MAX_MESSAGE = LVCP_MAX_MESSAGE
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] ch
  input  logic         in_tuser,   // [0] start_req
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // [15:0] command, [31:16] device, [47:32] sensor,
                                   // [63:48] x_pos, [79:64] y_pos, [95:80] precision,
                                   // [105:96] text_start, [116:106] text_length,
                                   // [118:117] status, [134:119] line_count,
                                   // [150:135] char_count, [151] zero
  output logic [1:0]   out_tuser   // [1:0] kind
);

  logic       accept;
  logic       pop;
  logic [1:0] res_cnt;
  result_t    res0, res1, head;
  q_status_t  qs;

  assign accept = in_tvalid && in_tready;
  assign pop    = out_tvalid && out_tready;

  // The parser state advances only on an accepted beat.
  lvcp_core #(
    .MAX_MESSAGE(MAX_MESSAGE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .ch        (in_tdata),
    .start_req (in_tuser),
    .res_cnt   (res_cnt),
    .res0      (res0),
    .res1      (res1)
  );

  lvcp_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_cnt (accept ? res_cnt : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .pop      (pop),
    .head     (head),
    .status   (qs)
  );

  assign in_tready  = qs.room;
  assign out_tvalid = qs.head_valid;
  assign out_tuser  = head.kind;
  assign out_tdata  = {1'b0, head.char_count, head.line_count, head.status,
                       head.text_length, head.text_start, head.precision, head.y_pos,
                       head.x_pos, head.sensor, head.device, head.command};

`ifndef SYNTHESIS
  // A pair of results is always a command followed by the end of the message.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_cnt == 2'd2 |-> res0.kind != KIND_END && res1.kind == KIND_END)
    else $error("two results without a command then an end");

  // A result only ever becomes visible after an accepted input beat.
  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_tvalid) && out_tvalid |-> $past(accept))
    else $error("result appeared without an accepted input");

  // Error codes are carried only by end-of-message results.
  a_status_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_END |-> head.status == ST_OK)
    else $error("command result carries an error status");

  // Input back-pressure only comes from results waiting at the output.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");
`endif

endmodule
